>>> sv/assert_macros.svh
// Assertion macros for the sky box point accumulator RTL.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define SBPA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define SBPA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/sbpa_pkg.sv
// Shared constants and types for the sky box point accumulator.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sbpa_pkg;

  localparam int ANGLE_FRAC_BITS = 16;
  localparam int LON_W = 25;
  localparam int LAT_W = 24;

  localparam logic [LON_W-1:0] FULL_TURN = LON_W'(360 << ANGLE_FRAC_BITS);
  localparam logic signed [LAT_W-1:0] QUARTER_TURN = LAT_W'(90 << ANGLE_FRAC_BITS);
  localparam logic signed [LAT_W-1:0] NEG_QUARTER_TURN = -QUARTER_TURN;

  typedef struct packed {
    logic                    empty;
    logic signed [LAT_W-1:0] lat_min;
    logic signed [LAT_W-1:0] lat_max;
    logic [LON_W-1:0]        lon_beg;
    logic [LON_W-1:0]        lon_end;
  } sbpa_box_t;

  typedef struct packed {
    logic was_inside;
    logic rejected;
  } sbpa_flags_t;

  localparam sbpa_box_t BOX_CLEAR = '{
    empty:   1'b1,
    lat_min: '0,
    lat_max: '0,
    lon_beg: '0,
    lon_end: '0
  };

endpackage

`default_nettype wire

>>> sv/sbpa_box_update.sv
// Next-box logic: range check, inside test and box widening for one point.
// Depends on sbpa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sbpa_box_update (
  input  var sbpa_pkg::sbpa_box_t                 box_cur,
  input  var logic [sbpa_pkg::LON_W-1:0]          lon,
  input  var logic signed [sbpa_pkg::LAT_W-1:0]   lat,
  input  var logic                                restart,
  output sbpa_pkg::sbpa_box_t                     box_nxt,
  output sbpa_pkg::sbpa_flags_t                   flags
);
  import sbpa_pkg::*;

  localparam int EXT_W = LON_W + 2;

  sbpa_box_t                base;
  logic                     bad;
  logic                     wraps;
  logic                     lon_in;
  logic                     pt_in;
  logic signed [EXT_W-1:0]  lon_x;
  logic signed [EXT_W-1:0]  beg_x;
  logic signed [EXT_W-1:0]  end_x;
  logic signed [EXT_W-1:0]  full_x;
  logic signed [EXT_W-1:0]  d_west;
  logic signed [EXT_W-1:0]  d_east;
  logic signed [EXT_W-1:0]  gap_west;
  logic signed [EXT_W-1:0]  gap_east;
  logic                     move_end;

  always_comb begin
    base = restart ? BOX_CLEAR : box_cur;

    bad = (lon >= FULL_TURN) || (lat < NEG_QUARTER_TURN) || (lat > QUARTER_TURN);

    wraps = base.lon_beg > base.lon_end;
    if (wraps) begin
      lon_in = (lon >= base.lon_beg) || (lon <= base.lon_end);
    end else begin
      lon_in = (lon >= base.lon_beg) && (lon <= base.lon_end);
    end
    pt_in = !bad && !base.empty && (lat >= base.lat_min) && (lat <= base.lat_max) &&
            lon_in;

    lon_x  = {2'b00, lon};
    beg_x  = {2'b00, base.lon_beg};
    end_x  = {2'b00, base.lon_end};
    full_x = {2'b00, FULL_TURN};

    d_west   = beg_x - lon_x;
    d_east   = lon_x - end_x;
    gap_west = full_x - end_x + lon_x;
    gap_east = full_x - lon_x + beg_x;

    // pick the longitude bound that keeps the box narrower
    if (wraps) begin
      move_end = d_west > d_east;
    end else if (lon < base.lon_beg) begin
      move_end = !(d_west <= gap_west);
    end else begin
      move_end = d_east <= gap_east;
    end

    box_nxt = base;
    if (!bad && !pt_in) begin
      if (base.empty) begin
        box_nxt.empty   = 1'b0;
        box_nxt.lat_min = lat;
        box_nxt.lat_max = lat;
        box_nxt.lon_beg = lon;
        box_nxt.lon_end = lon;
      end else begin
        if (lat < base.lat_min) begin
          box_nxt.lat_min = lat;
        end
        if (lat > base.lat_max) begin
          box_nxt.lat_max = lat;
        end
        if (move_end) begin
          box_nxt.lon_end = lon;
        end else begin
          box_nxt.lon_beg = lon;
        end
      end
    end

    flags.was_inside = pt_in;
    flags.rejected   = bad;
  end

endmodule

`default_nettype wire

>>> sv/sky_box_point_accumulator_core.sv
// Sky box point accumulator, top level.
// The result word for an accepted point is registered and shows on the out_ ports in the cycle after it is accepted.
// Throughput: one point per cycle while in_stall is low; box state updates in a single pass per point.
// in_stall is raised only while a result word is held and out_stall is high.
// Reset (rst_n low, synchronous) empties the box and drops any pending result.
// Depends on sbpa_pkg, sbpa_box_update and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module sky_box_point_accumulator_core (
  input  var logic                               clk,
  input  var logic                               rst_n,
  input  var logic                               in_valid,
  output logic                                   in_stall,
  input  var logic [sbpa_pkg::LON_W-1:0]         in_lon,
  input  var logic signed [sbpa_pkg::LAT_W-1:0]  in_lat,
  input  var logic                               in_restart,
  output logic                                   out_valid,
  input  var logic                               out_stall,
  output logic                                   out_box_empty,
  output logic signed [sbpa_pkg::LAT_W-1:0]      out_lat_low,
  output logic signed [sbpa_pkg::LAT_W-1:0]      out_lat_high,
  output logic [sbpa_pkg::LON_W-1:0]             out_lon_begin,
  output logic [sbpa_pkg::LON_W-1:0]             out_lon_end,
  output logic                                   out_was_inside,
  output logic                                   out_rejected
);
  import sbpa_pkg::*;

  sbpa_box_t   box_r;
  sbpa_box_t   box_nxt;
  sbpa_flags_t flags;
  sbpa_box_t   res_box_r;
  sbpa_flags_t res_flags_r;
  logic        out_valid_r;
  logic        out_valid_nxt;
  logic        in_acc;

  sbpa_box_update u_update (
    .box_cur (box_r),
    .lon     (in_lon),
    .lat     (in_lat),
    .restart (in_restart),
    .box_nxt (box_nxt),
    .flags   (flags)
  );

  assign in_stall = out_valid_r && out_stall;
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    if (in_acc) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_r       <= BOX_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_acc) begin
        box_r <= box_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      res_box_r   <= box_nxt;
      res_flags_r <= flags;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_box_empty  = res_box_r.empty;
  assign out_lat_low    = res_box_r.lat_min;
  assign out_lat_high   = res_box_r.lat_max;
  assign out_lon_begin  = res_box_r.lon_beg;
  assign out_lon_end    = res_box_r.lon_end;
  assign out_was_inside = res_flags_r.was_inside;
  assign out_rejected   = res_flags_r.rejected;

  `SBPA_ASSERT(a_inside_excl_reject, out_valid_r |-> !(out_rejected && out_was_inside), "inside and rejected both set")
  `SBPA_ASSERT(a_lat_order, (out_valid_r && !out_box_empty) |-> (out_lat_low <= out_lat_high), "box latitude bounds out of order")
  `SBPA_ASSERT(a_empty_not_inside, (out_valid_r && out_box_empty) |-> !out_was_inside, "point inside an empty box")
  `SBPA_ASSERT(a_restart_bad_empties, (in_acc && in_restart && (in_lon >= FULL_TURN)) |=> out_box_empty, "restart with a bad point left box filled")

endmodule

`default_nettype wire

>>> test/sky_box_point_accumulator_core_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for sky_box_point_accumulator_core: a directed table, then random
// point streams under four idle/stall mixes, each result word checked against a box predictor.
// Depends on sbpa_pkg and the core RTL.

module sky_box_point_accumulator_core_tb;
  import sbpa_pkg::*;

  localparam int TURN        = 360 << ANGLE_FRAC_BITS;
  localparam int QUARTER     = 90 << ANGLE_FRAC_BITS;
  localparam int DEG         = 1 << ANGLE_FRAC_BITS;
  localparam int LON_TOP     = (1 << LON_W) - 1;
  localparam int LAT_TOP     = (1 << (LAT_W - 1)) - 1;
  localparam int CYCLE_LIMIT = 200000;
  localparam int REPORT_MAX  = 10;

  typedef struct packed {
    logic                    empty;
    logic signed [LAT_W-1:0] lat_low;
    logic signed [LAT_W-1:0] lat_high;
    logic [LON_W-1:0]        lon_begin;
    logic [LON_W-1:0]        lon_end;
    logic                    was_inside;
    logic                    rejected;
  } box_word_t;

  typedef struct {
    logic [LON_W-1:0]        lon;
    logic signed [LAT_W-1:0] lat;
    logic                    restart;
    bit                      typed;
    box_word_t               res;
  } point_row_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [LON_W-1:0]        in_lon = '0;
  logic signed [LAT_W-1:0] in_lat = '0;
  logic                    in_restart = 1'b0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic                    out_box_empty;
  logic signed [LAT_W-1:0] out_lat_low;
  logic signed [LAT_W-1:0] out_lat_high;
  logic [LON_W-1:0]        out_lon_begin;
  logic [LON_W-1:0]        out_lon_end;
  logic                    out_was_inside;
  logic                    out_rejected;

  sbpa_box_t  sky_box = BOX_CLEAR;
  point_row_t point_q[$];
  box_word_t  box_q[$];
  int         send_idle_pct = 0;
  int         stall_pct = 0;
  int         cycles = 0;
  int         mismatches = 0;
  int         points_sent = 0;
  int         words_checked = 0;

  sky_box_point_accumulator_core i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_lon         (in_lon),
    .in_lat         (in_lat),
    .in_restart     (in_restart),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_box_empty  (out_box_empty),
    .out_lat_low    (out_lat_low),
    .out_lat_high   (out_lat_high),
    .out_lon_begin  (out_lon_begin),
    .out_lon_end    (out_lon_end),
    .out_was_inside (out_was_inside),
    .out_rejected   (out_rejected)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic box_word_t take_point(logic [LON_W-1:0] lon, logic signed [LAT_W-1:0] lat,
                                           logic restart);
    longint pl, pt, beg, fin, lo, hi;
    logic   bad, hit;
    if (restart) sky_box = BOX_CLEAR;
    pl  = longint'(lon);
    pt  = longint'(lat);
    beg = longint'(sky_box.lon_beg);
    fin = longint'(sky_box.lon_end);
    lo  = longint'(sky_box.lat_min);
    hi  = longint'(sky_box.lat_max);
    bad = pl >= TURN || pt < -QUARTER || pt > QUARTER;
    hit = !bad && !sky_box.empty && pt >= lo && pt <= hi &&
          ((beg > fin) ? (pl >= beg || pl <= fin) : (pl >= beg && pl <= fin));
    if (!bad && !hit) begin
      if (sky_box.empty) begin
        sky_box = '{1'b0, lat, lat, lon, lon};
      end else begin
        if (pt < lo) sky_box.lat_min = lat;
        if (pt > hi) sky_box.lat_max = lat;
        if (beg > fin) begin
          if (beg - pl > pl - fin) sky_box.lon_end = lon;
          else sky_box.lon_beg = lon;
        end else if (pl < beg) begin
          if (beg - pl <= TURN - fin + pl) sky_box.lon_beg = lon;
          else sky_box.lon_end = lon;
        end else if (pl - fin <= TURN - pl + beg) begin
          sky_box.lon_end = lon;
        end else begin
          sky_box.lon_beg = lon;
        end
      end
    end
    return '{sky_box.empty, sky_box.lat_min, sky_box.lat_max, sky_box.lon_beg,
             sky_box.lon_end, hit, bad};
  endfunction

  function automatic point_row_t row(int lon, int lat, bit restart, bit typed = 0,
                                     bit e = 0, int lo = 0, int hi = 0, int beg = 0,
                                     int fin = 0, bit ins = 0, bit rej = 0);
    point_row_t r;
    r.lon     = LON_W'(lon);
    r.lat     = LAT_W'(lat);
    r.restart = restart;
    r.typed   = typed;
    r.res     = '{e, LAT_W'(lo), LAT_W'(hi), LON_W'(beg), LON_W'(fin), ins, rej};
    return r;
  endfunction

  function automatic void check_word(box_word_t want, box_word_t got);
    if (got.empty !== want.empty || got.lat_low !== want.lat_low ||
        got.lat_high !== want.lat_high || got.lon_begin !== want.lon_begin ||
        got.lon_end !== want.lon_end || got.was_inside !== want.was_inside ||
        got.rejected !== want.rejected) begin
      mismatches++;
      if (mismatches <= REPORT_MAX) begin
        $display("word %0d expected: empty=%0d lat=[%0d,%0d] lon=[%0d,%0d] in=%0d rej=%0d",
                 words_checked, want.empty, want.lat_low, want.lat_high, want.lon_begin,
                 want.lon_end, want.was_inside, want.rejected);
        $display("word %0d actual:   empty=%0d lat=[%0d,%0d] lon=[%0d,%0d] in=%0d rej=%0d",
                 words_checked, got.empty, got.lat_low, got.lat_high, got.lon_begin,
                 got.lon_end, got.was_inside, got.rejected);
      end
    end
  endfunction

  task automatic queue_random(int count);
    int                      kind, lo, hi, v;
    logic [LON_W-1:0]        lon;
    logic signed [LAT_W-1:0] lat;
    logic                    restart;
    point_row_t              p;
    repeat (count) begin
      kind    = $urandom_range(99);
      restart = ($urandom_range(99) < 5);
      lon     = LON_W'($urandom_range(TURN - 1));
      lat     = LAT_W'(int'($urandom_range(2 * QUARTER)) - QUARTER);
      if (kind < 8) begin
        if ($urandom_range(1)) lon = LON_W'($urandom_range(LON_TOP, TURN));
        else if ($urandom_range(1)) lat = LAT_W'(QUARTER + 1 + $urandom_range(LAT_TOP - QUARTER - 1));
        else lat = LAT_W'(-QUARTER - 1 - int'($urandom_range(LAT_TOP - QUARTER)));
      end else if (kind < 30 && !sky_box.empty) begin
        lo  = sky_box.lat_min;
        hi  = sky_box.lat_max;
        lat = LAT_W'(lo + int'($urandom_range(hi - lo)));
        if (sky_box.lon_beg <= sky_box.lon_end)
          lon = LON_W'($urandom_range(sky_box.lon_end, sky_box.lon_beg));
        else if ($urandom_range(1)) lon = LON_W'($urandom_range(TURN - 1, sky_box.lon_beg));
        else lon = LON_W'($urandom_range(sky_box.lon_end, 0));
      end else if (kind < 50 && !sky_box.empty) begin
        v = $urandom_range(4 * DEG);
        if ($urandom_range(1)) lon = LON_W'((int'(sky_box.lon_end) + v) % TURN);
        else lon = LON_W'((int'(sky_box.lon_beg) - v + TURN) % TURN);
        if ($urandom_range(1)) begin
          v = $urandom_range(1) ? int'(sky_box.lat_max) + int'($urandom_range(2 * DEG))
                                : int'(sky_box.lat_min) - int'($urandom_range(2 * DEG));
          if (v > QUARTER) v = QUARTER;
          if (v < -QUARTER) v = -QUARTER;
          lat = LAT_W'(v);
        end
      end else if (kind < 60) begin
        lon = $urandom_range(1) ? LON_W'(TURN - 1) : LON_W'(0);
        case ($urandom_range(2))
          0: lat = LAT_W'(QUARTER);
          1: lat = LAT_W'(-QUARTER);
          default: lat = '0;
        endcase
      end
      p.lon     = lon;
      p.lat     = lat;
      p.restart = restart;
      p.typed   = 1'b0;
      p.res     = take_point(lon, lat, restart);
      point_q.push_back(p);
    end
  endtask

  task automatic feed_points();
    while (point_q.size() > 0) begin
      @(posedge clk);
      if (in_valid && !in_stall) begin
        box_q.push_back(point_q[0].res);
        point_q.delete(0);
        points_sent++;
      end
      if (!(in_valid && in_stall)) begin
        if (point_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid   <= 1'b1;
          in_lon     <= point_q[0].lon;
          in_lat     <= point_q[0].lat;
          in_restart <= point_q[0].restart;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  endtask

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    box_word_t got;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      got = '{out_box_empty, out_lat_low, out_lat_high, out_lon_begin, out_lon_end,
              out_was_inside, out_rejected};
      if (box_q.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("word %0d arrived with no point pending", words_checked);
      end else begin
        check_word(box_q[0], got);
        box_q.delete(0);
      end
      words_checked++;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycles, box_q.size());
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    point_row_t dir_tab[$];
    box_word_t  res;
    // out of range on an empty box, then extremes, wrap and restart cases
    dir_tab.push_back(row(TURN, 0, 0, 1, 1, 0, 0, 0, 0, 0, 1));
    dir_tab.push_back(row(LON_TOP, 0, 0, 1, 1, 0, 0, 0, 0, 0, 1));
    dir_tab.push_back(row(0, -QUARTER - 1, 0, 1, 1, 0, 0, 0, 0, 0, 1));
    dir_tab.push_back(row(0, QUARTER + 1, 0, 1, 1, 0, 0, 0, 0, 0, 1));
    dir_tab.push_back(row(0, -LAT_TOP - 1, 0, 1, 1, 0, 0, 0, 0, 0, 1));
    dir_tab.push_back(row(0, LAT_TOP, 0, 1, 1, 0, 0, 0, 0, 0, 1));
    dir_tab.push_back(row(TURN - 1, QUARTER, 0, 1, 0, QUARTER, QUARTER, TURN - 1, TURN - 1, 0, 0));
    dir_tab.push_back(row(TURN - 1, QUARTER, 0, 1, 0, QUARTER, QUARTER, TURN - 1, TURN - 1, 1, 0));
    dir_tab.push_back(row(0, -QUARTER, 0, 1, 0, -QUARTER, QUARTER, TURN - 1, 0, 0, 0));
    dir_tab.push_back(row(0, 0, 0, 1, 0, -QUARTER, QUARTER, TURN - 1, 0, 1, 0));
    dir_tab.push_back(row(LON_TOP, -LAT_TOP - 1, 1, 1, 1, 0, 0, 0, 0, 0, 1));
    dir_tab.push_back(row(100 * DEG, 10 * DEG, 0));
    dir_tab.push_back(row(280 * DEG, 10 * DEG, 0));
    dir_tab.push_back(row(190 * DEG, -5 * DEG, 0));
    dir_tab.push_back(row(200 * DEG, 0, 1));
    dir_tab.push_back(row(20 * DEG, 0, 0));
    dir_tab.push_back(row(300 * DEG, 0, 1));
    dir_tab.push_back(row(60 * DEG, 0, 0));
    dir_tab.push_back(row(180 * DEG, 0, 0));
    dir_tab.push_back(row(100 * DEG, 0, 0));
    dir_tab.push_back(row(0, 0, 1));
    dir_tab.push_back(row(TURN - 1, 0, 0));
    dir_tab.push_back(row(TURN - 1, -1, 0));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[i]) begin
      res = take_point(dir_tab[i].lon, dir_tab[i].lat, dir_tab[i].restart);
      if (!dir_tab[i].typed) dir_tab[i].res = res;
      point_q.push_back(dir_tab[i]);
    end

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct <= 0;  stall_pct <= 0;  end
        1: begin send_idle_pct <= 80; stall_pct <= 0;  end
        2: begin send_idle_pct <= 0;  stall_pct <= 80; end
        default: begin send_idle_pct <= 38; stall_pct <= 38; end
      endcase
      queue_random(phase == 0 ? 200 : 250);
      feed_points();
      while (box_q.size() > 0) @(posedge clk);
      repeat (4) @(posedge clk);
    end

    if (box_q.size() > 0) begin
      mismatches += box_q.size();
      $display("%0d result words never arrived", box_q.size());
    end
    $display("%0d points (out-of-range, restarts, wrap and tie cases, inside hits) under",
             points_sent);
    $display("four sender/receiver idle mixes; %0d words checked, %0d mismatches",
             words_checked, mismatches);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
